[sv/vmd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the voxel moment downsampler.
package vmd_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int FRAC_BITS   = 14;
	localparam int COORD_W     = $clog2(MAX_SIDE);
	localparam int SIZE_W      = 7;
	localparam int HALF_SIDE   = (MAX_SIDE + 1) / 2;
	localparam int HALF_W      = $clog2(HALF_SIDE + 1);
	localparam int STORE_DEPTH = HALF_SIDE * HALF_SIDE * HALF_SIDE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int ROW_W       = $clog2(HALF_SIDE * HALF_SIDE);
	localparam int ROW_PW      = COORD_W - 1 + HALF_W;
	localparam int CELL_PW     = ROW_W + HALF_W;
	localparam int VOL_PW      = 3 * HALF_W;
	localparam int TERM_W      = 2 * COORD_W;
	localparam int DENS_W      = 16;
	localparam int IDX_W       = 15;
	localparam int MOM_W       = 31;
	localparam int ACC_W       = MOM_W + 1;
	localparam int PROD_W      = (TERM_W + DENS_W + 1 > TERM_W + FRAC_BITS + 1) ?
		(TERM_W + DENS_W + 1) : (TERM_W + FRAC_BITS + 1);
	localparam int SAT_W       = (PROD_W > MOM_W) ? PROD_W : MOM_W + 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;
	localparam int MOM_MAX     = 2 ** (MOM_W - 1) - 1;
	localparam int MOM_MIN     = -(2 ** (MOM_W - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOMENT_KIND  = 3'd0,
		REG_WEIGHT       = 3'd1,
		REG_DS_ENABLE    = 3'd2,
		REG_SIZE_X       = 3'd3,
		REG_SIZE_Y       = 3'd4,
		REG_SIZE_Z       = 3'd5
	} cfg_reg_e;

	typedef enum logic [1:0] {
		KIND_FIRST  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CROSS  = 2'd2
	} moment_kind_e;

	typedef enum logic {
		OP_VOXEL = 1'b0,
		OP_READ  = 1'b1
	} op_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TERM,
		ST_MUL,
		ST_READ,
		ST_WRITE
	} state_e;

	typedef struct packed {
		logic [SIZE_W-1:0] sx;
		logic [SIZE_W-1:0] sy;
		logic [SIZE_W-1:0] sz;
	} sizes_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               done;
	} coord_t;

	function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		if (s == '0)
			r = SIZE_W'(1);
		else if (s > SIZE_W'(MAX_SIDE))
			r = SIZE_W'(MAX_SIDE);
		else
			r = s;
		return r;
	endfunction

	function automatic logic signed [MOM_W-1:0] make_term(logic [TERM_W-1:0] t,
		logic signed [DENS_W-1:0] d, logic w);
		logic signed [SAT_W-1:0] v;
		if (w)
			v = SAT_W'($signed({1'b0, t})) * SAT_W'(d);
		else
			v = SAT_W'($signed({1'b0, t})) <<< FRAC_BITS;
		if (v > SAT_W'(MOM_MAX))
			return MOM_W'(MOM_MAX);
		else if (v < SAT_W'(MOM_MIN))
			return MOM_W'(MOM_MIN);
		else
			return v[MOM_W-1:0];
	endfunction

	function automatic logic signed [MOM_W-1:0] add_sat(logic signed [MOM_W-1:0] a,
		logic signed [MOM_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		s = ACC_W'(a) + ACC_W'(b);
		if (s > ACC_W'(MOM_MAX))
			return MOM_W'(MOM_MAX);
		else if (s < ACC_W'(MOM_MIN))
			return MOM_W'(MOM_MIN);
		else
			return s[MOM_W-1:0];
	endfunction

endpackage

[sv/vmd_in_if.sv]
`timescale 1ns / 1ps
// Input channel: voxel densities and cell read requests.
interface vmd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic signed [vmd_pkg::DENS_W-1:0]    density;
	logic [vmd_pkg::IDX_W-1:0]            cell_index;

	modport source(output valid, operation, density, cell_index, input ready);
	modport sink(input valid, operation, density, cell_index, output ready);
endinterface

[sv/vmd_out_if.sv]
`timescale 1ns / 1ps
// Output channel: moment triples and cell sums.
interface vmd_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [vmd_pkg::MOM_W-1:0]   moment_a;
	logic signed [vmd_pkg::MOM_W-1:0]   moment_b;
	logic signed [vmd_pkg::MOM_W-1:0]   moment_c;
	logic                               is_cell_sum;
	logic                               volume_done;

	modport source(output valid, moment_a, moment_b, moment_c, is_cell_sum, volume_done,
		input ready);
	modport sink(input valid, moment_a, moment_b, moment_c, is_cell_sum, volume_done,
		output ready);
endinterface

[sv/voxel_moment_downsample.sv]
`timescale 1ns / 1ps
// Voxel geometric moment generator with half-resolution box-sum store.
//
// voxel: valid/ready channel. operation 0 delivers one density in raster order
//   (x fastest); the block tracks coordinates itself. operation 1 reads one
//   summed cell of the half-resolution store at cell_index.
// result: valid/ready channel, one transfer per accepted item: the moment
//   triple (or cell sum), is_cell_sum, and volume_done on the last voxel.
// cfg_we/cfg_index/cfg_data: register writes, only while the block is idle
// (the user's rule; the block does not enforce it). Each item runs through
// five steps: accept, coordinate terms, density multiply and cell address,
// store read, store write-back. The result register is loaded at the end of
// write-back; a new item is taken only once the previous one has left it.
// The result register holds a finished item while the next one is already
// being worked on; if result stays stalled the sequencer waits in write-back.
// Reset clears the registers to their defaults and the coordinates to zero.
// The store is not cleared; a cell is valid once its even-corner voxel has
// written it with downsampling enabled.
module voxel_moment_downsample (
	input  logic                           clk,
	input  logic                           arst_n,
	vmd_in_if.sink                         voxel,
	vmd_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [vmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vmd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int MW = vmd_pkg::MOM_W;

	vmd_pkg::state_e            state_q, state_d;
	logic [1:0]                 kind_q;
	logic                       weight_q, ds_en_q;
	logic [vmd_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	vmd_pkg::sizes_t            sizes;
	logic [vmd_pkg::HALF_W-1:0] hx, hy, hz;
	vmd_pkg::coord_t            cur;
	logic                       acc, out_free, ram_we;

	logic                              op_s1, done_s1;
	logic signed [vmd_pkg::DENS_W-1:0] dens_s1;
	logic [vmd_pkg::IDX_W-1:0]         idx_s1;
	logic [vmd_pkg::COORD_W-1:0]       x_s1, y_s1, z_s1;

	logic [vmd_pkg::TERM_W-1:0]   ta, tb, tc, ta_s2, tb_s2, tc_s2;
	logic [vmd_pkg::ROW_PW-1:0]   row_prod;
	logic [vmd_pkg::ROW_W-1:0]    row_s2;
	logic [2*vmd_pkg::HALF_W-1:0] hxy_s2;

	logic [vmd_pkg::CELL_PW-1:0]  cell_prod;
	logic [vmd_pkg::VOL_PW-1:0]   vol_prod;
	logic signed [MW-1:0]         ma_s3, mb_s3, mc_s3;
	logic [vmd_pkg::ADDR_W-1:0]   cell_s3;
	logic                         in_range_s3, even_s3;

	logic [3*MW-1:0]      rd_data, wr_data;
	logic signed [MW-1:0] old_a, old_b, old_c;

	logic                 out_valid_q, cell_sum_q, vol_done_q;
	logic signed [MW-1:0] out_a_q, out_b_q, out_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= vmd_pkg::KIND_FIRST;
			weight_q <= 1'b1;
			ds_en_q  <= 1'b0;
			size_x_q <= vmd_pkg::SIZE_W'(vmd_pkg::MAX_SIDE);
			size_y_q <= vmd_pkg::SIZE_W'(vmd_pkg::MAX_SIDE);
			size_z_q <= vmd_pkg::SIZE_W'(vmd_pkg::MAX_SIDE);
		end else if (cfg_we) begin
			case (cfg_index)
				vmd_pkg::REG_MOMENT_KIND: kind_q   <= cfg_data[1:0];
				vmd_pkg::REG_WEIGHT:      weight_q <= cfg_data[0];
				vmd_pkg::REG_DS_ENABLE:   ds_en_q  <= cfg_data[0];
				vmd_pkg::REG_SIZE_X:      size_x_q <= cfg_data;
				vmd_pkg::REG_SIZE_Y:      size_y_q <= cfg_data;
				vmd_pkg::REG_SIZE_Z:      size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		sizes.sx = vmd_pkg::eff_size(size_x_q);
		sizes.sy = vmd_pkg::eff_size(size_y_q);
		sizes.sz = vmd_pkg::eff_size(size_z_q);
	end

	assign hx = vmd_pkg::HALF_W'(({1'b0, sizes.sx} + 8'd1) >> 1);
	assign hy = vmd_pkg::HALF_W'(({1'b0, sizes.sy} + 8'd1) >> 1);
	assign hz = vmd_pkg::HALF_W'(({1'b0, sizes.sz} + 8'd1) >> 1);

	vmd_coord u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (acc && voxel.operation == vmd_pkg::OP_VOXEL),
		.sizes   (sizes),
		.cur     (cur)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= vmd_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_d     = state_q;
		voxel.ready = 1'b0;
		case (state_q)
			vmd_pkg::ST_IDLE: begin
				voxel.ready = 1'b1;
				if (voxel.valid)
					state_d = vmd_pkg::ST_TERM;
			end
			vmd_pkg::ST_TERM:  state_d = vmd_pkg::ST_MUL;
			vmd_pkg::ST_MUL:   state_d = vmd_pkg::ST_READ;
			vmd_pkg::ST_READ:  state_d = vmd_pkg::ST_WRITE;
			vmd_pkg::ST_WRITE: begin
				if (out_free)
					state_d = vmd_pkg::ST_IDLE;
			end
			default: state_d = vmd_pkg::ST_IDLE;
		endcase
	end

	assign acc = voxel.valid && voxel.ready;

	// accept
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= voxel.operation;
			dens_s1 <= voxel.density;
			idx_s1  <= voxel.cell_index;
			x_s1    <= cur.x;
			y_s1    <= cur.y;
			z_s1    <= cur.z;
			done_s1 <= (voxel.operation == vmd_pkg::OP_VOXEL) && cur.done;
		end
	end

	// coordinate terms and row of the cell address
	always_comb begin
		case (kind_q)
			vmd_pkg::KIND_SQUARE: begin
				ta = vmd_pkg::TERM_W'(x_s1) * vmd_pkg::TERM_W'(x_s1);
				tb = vmd_pkg::TERM_W'(y_s1) * vmd_pkg::TERM_W'(y_s1);
				tc = vmd_pkg::TERM_W'(z_s1) * vmd_pkg::TERM_W'(z_s1);
			end
			vmd_pkg::KIND_CROSS: begin
				ta = vmd_pkg::TERM_W'(x_s1) * vmd_pkg::TERM_W'(y_s1);
				tb = vmd_pkg::TERM_W'(y_s1) * vmd_pkg::TERM_W'(z_s1);
				tc = vmd_pkg::TERM_W'(z_s1) * vmd_pkg::TERM_W'(x_s1);
			end
			default: begin
				ta = {{vmd_pkg::COORD_W{1'b0}}, x_s1};
				tb = {{vmd_pkg::COORD_W{1'b0}}, y_s1};
				tc = {{vmd_pkg::COORD_W{1'b0}}, z_s1};
			end
		endcase
		row_prod = vmd_pkg::ROW_PW'(z_s1[vmd_pkg::COORD_W-1:1]) * vmd_pkg::ROW_PW'(hy) +
			vmd_pkg::ROW_PW'(y_s1[vmd_pkg::COORD_W-1:1]);
	end

	always_ff @(posedge clk) begin
		if (state_q == vmd_pkg::ST_TERM) begin
			ta_s2  <= ta;
			tb_s2  <= tb;
			tc_s2  <= tc;
			row_s2 <= row_prod[vmd_pkg::ROW_W-1:0];
			hxy_s2 <= {{vmd_pkg::HALF_W{1'b0}}, hx} * {{vmd_pkg::HALF_W{1'b0}}, hy};
		end
	end

	// density multiply, cell address, read range check
	always_comb begin
		cell_prod = vmd_pkg::CELL_PW'(row_s2) * vmd_pkg::CELL_PW'(hx) +
			vmd_pkg::CELL_PW'(x_s1[vmd_pkg::COORD_W-1:1]);
		vol_prod  = vmd_pkg::VOL_PW'(hxy_s2) * vmd_pkg::VOL_PW'(hz);
	end

	always_ff @(posedge clk) begin
		if (state_q == vmd_pkg::ST_MUL) begin
			ma_s3       <= vmd_pkg::make_term(ta_s2, dens_s1, weight_q);
			mb_s3       <= vmd_pkg::make_term(tb_s2, dens_s1, weight_q);
			mc_s3       <= vmd_pkg::make_term(tc_s2, dens_s1, weight_q);
			cell_s3     <= (op_s1 == vmd_pkg::OP_READ) ? vmd_pkg::ADDR_W'(idx_s1) :
				cell_prod[vmd_pkg::ADDR_W-1:0];
			in_range_s3 <= vmd_pkg::VOL_PW'(idx_s1) < vol_prod;
			even_s3     <= !(x_s1[0] || y_s1[0] || z_s1[0]);
		end
	end

	// store read-modify-write
	assign old_a = rd_data[3*MW-1:2*MW];
	assign old_b = rd_data[2*MW-1:MW];
	assign old_c = rd_data[MW-1:0];

	assign wr_data = even_s3 ? {ma_s3, mb_s3, mc_s3} :
		{vmd_pkg::add_sat(old_a, ma_s3), vmd_pkg::add_sat(old_b, mb_s3),
		vmd_pkg::add_sat(old_c, mc_s3)};

	assign ram_we = state_q == vmd_pkg::ST_WRITE && out_free && ds_en_q &&
		op_s1 == vmd_pkg::OP_VOXEL;

	vmd_ram #(
		.WIDTH (3 * MW),
		.DEPTH (vmd_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cell_s3),
		.wdata (wr_data),
		.re    (state_q == vmd_pkg::ST_READ),
		.raddr (cell_s3),
		.rdata (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == vmd_pkg::ST_WRITE && out_free)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == vmd_pkg::ST_WRITE && out_free) begin
			cell_sum_q <= op_s1;
			vol_done_q <= done_s1;
			if (op_s1 == vmd_pkg::OP_READ) begin
				out_a_q <= in_range_s3 ? old_a : '0;
				out_b_q <= in_range_s3 ? old_b : '0;
				out_c_q <= in_range_s3 ? old_c : '0;
			end else begin
				out_a_q <= ma_s3;
				out_b_q <= mb_s3;
				out_c_q <= mc_s3;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.moment_a    = out_a_q;
	assign result.moment_b    = out_b_q;
	assign result.moment_c    = out_c_q;
	assign result.is_cell_sum = cell_sum_q;
	assign result.volume_done = vol_done_q;

	a_we_voxel_only: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == vmd_pkg::ST_WRITE && op_s1 == vmd_pkg::OP_VOXEL && ds_en_q)
		else $error("store written outside voxel write-back");

	a_result_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vmd_pkg::ST_WRITE && out_free |=>
		result.valid && state_q == vmd_pkg::ST_IDLE)
		else $error("write-back did not load the result register");

	a_read_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_cell_sum |-> !result.volume_done)
		else $error("cell read flagged end of volume");

endmodule

[sv/vmd_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module vmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/vmd_coord.sv]
`timescale 1ns / 1ps
// Raster-order voxel coordinate tracker with stale-coordinate wrap.
module vmd_coord (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  vmd_pkg::sizes_t sizes,
	output vmd_pkg::coord_t cur
);

	logic [vmd_pkg::COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic                        x_last, y_last, z_last;
	logic [vmd_pkg::SIZE_W-1:0]  x_inc, y_inc, z_inc;

	always_comb begin
		cur.x = ({1'b0, pos_x_q} >= sizes.sx) ? '0 : pos_x_q;
		cur.y = ({1'b0, pos_y_q} >= sizes.sy) ? '0 : pos_y_q;
		cur.z = ({1'b0, pos_z_q} >= sizes.sz) ? '0 : pos_z_q;
		x_inc = {1'b0, cur.x} + vmd_pkg::SIZE_W'(1);
		y_inc = {1'b0, cur.y} + vmd_pkg::SIZE_W'(1);
		z_inc = {1'b0, cur.z} + vmd_pkg::SIZE_W'(1);
		x_last = (x_inc >= sizes.sx);
		y_last = (y_inc >= sizes.sy);
		z_last = (z_inc >= sizes.sz);
		cur.done = x_last && y_last && z_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (advance) begin
			pos_y_q <= cur.y;
			pos_z_q <= cur.z;
			if (!x_last) begin
				pos_x_q <= x_inc[vmd_pkg::COORD_W-1:0];
			end else begin
				pos_x_q <= '0;
				if (!y_last) begin
					pos_y_q <= y_inc[vmd_pkg::COORD_W-1:0];
				end else begin
					pos_y_q <= '0;
					pos_z_q <= z_last ? '0 : z_inc[vmd_pkg::COORD_W-1:0];
				end
			end
		end
	end

	a_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cur.done |=> pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0)
		else $error("coordinates not cleared after last voxel");

	a_x_steps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !x_last |=> pos_x_q == $past(cur.x) + 1'b1 && pos_y_q == $past(cur.y))
		else $error("x coordinate did not step");

	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur.x} < sizes.sx && {1'b0, cur.y} < sizes.sy && {1'b0, cur.z} < sizes.sz)
		else $error("coordinate outside volume");

endmodule
